/* rtl/core/pmdr_pkg.sv */
`default_nettype none
package pmdr_pkg;

	localparam int ERR_W  = 11;
	localparam int MAG_W  = 11;
	localparam int DUTY_W = 7;
	localparam int DB_W   = 8;
	localparam int DIR_W  = 2;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 8;
	// excess magnitude times duty spread
	localparam int PROD_W = MAG_W + DUTY_W;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_DUTY   = 3'd0,
		REG_MAX_DUTY   = 3'd1,
		REG_DEADBAND   = 3'd2,
		REG_ACCEL_STEP = 3'd3,
		REG_DECEL_STEP = 3'd4
	} reg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

	localparam logic [DUTY_W-1:0] RST_MIN_DUTY   = 7'd15;
	localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 7'd80;
	localparam logic [DB_W-1:0]   RST_DEADBAND   = 8'd5;
	localparam logic [DUTY_W-1:0] RST_ACCEL_STEP = 7'd4;
	localparam logic [DUTY_W-1:0] RST_DECEL_STEP = 7'd6;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_RAMP = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

/* rtl/core/pmdr_if.sv */
`default_nettype none
interface pmdr_in_if import pmdr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] position_error;
	modport source(output valid, position_error, input ready);
	modport sink(input valid, position_error, output ready);
endinterface

interface pmdr_out_if import pmdr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_percent;
	logic              drive_enable;
	logic [DIR_W-1:0]  direction;
	modport source(output valid, duty_percent, drive_enable, direction, input ready);
	modport sink(input valid, duty_percent, drive_enable, direction, output ready);
endinterface

interface pmdr_cfg_if import pmdr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/pmdr_div.sv */
`default_nettype none
module pmdr_div import pmdr_pkg::*; #(
	parameter int DVD_W = 18,
	parameter int DVS_W = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output div_stat_t             stat,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             fits;

	// restoring division, one quotient bit per cycle, MSB first
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule
`default_nettype wire

/* rtl/core/proportional_motor_drive_with_ramp.sv */
// channel | dir | payload                                   | transfer when
// sample  | in  | position_error[10:0] signed               | valid & ready
// result  | out | duty_percent[6:0], drive_enable, direction | valid & ready
// cfg     | in  | index[2:0], data[7:0]                     | valid & ready (always ready)
//
// An item with error inside the deadband, or with a fixed target, goes from the prep
// state straight to the ramp step; a proportional item passes the divide state between
// them (18-bit serial divider, one quotient bit per cycle).
// sample.ready is high only while the sequencer is idle; one item is worked at a time.
// A held result does not block the next transfer; the ramp step waits for the slot.
// arst_n clears the sequencer, the duty/direction state and loads register defaults.
`default_nettype none
module proportional_motor_drive_with_ramp import pmdr_pkg::*; #(
	parameter int FULL_SCALE_ERROR = 1023
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pmdr_in_if.sink     sample,
	pmdr_out_if.source  result,
	pmdr_cfg_if.sink    cfg
);

	localparam int SPAN_W = $clog2(FULL_SCALE_ERROR + 1);
	localparam int CMP_W  = ((SPAN_W > 15) ? SPAN_W : 15) + 1;
	localparam logic [SPAN_W-1:0] FSE = SPAN_W'(FULL_SCALE_ERROR);

	state_t            state_q;
	logic [DUTY_W-1:0] min_q, max_q, accel_q, decel_q;
	logic [DB_W-1:0]   db_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic              outside_q;
	logic [DUTY_W-1:0] target_q;
	logic [DUTY_W-1:0] duty_q;
	dir_t              dir_q;
	logic              out_valid_q;

	logic [MAG_W-1:0]  err_u;
	logic              outside;
	logic [MAG_W-1:0]  excess;
	logic [SPAN_W-1:0] span;
	logic [MAG_W:0]    ex1;
	logic [CMP_W-1:0]  lim20;
	logic              min_gt_max;
	logic              div_start;
	logic [DUTY_W-1:0] spread;
	logic [PROD_W-1:0] product;
	logic [DUTY_W-1:0] prep_target;
	div_stat_t         dstat;
	logic [PROD_W-1:0] quot;
	logic [PROD_W:0]   prop_sum;
	logic [DUTY_W-1:0] prop_target;
	logic [DUTY_W-1:0] step_diff;
	logic [DUTY_W-1:0] duty_next;
	dir_t              dir_next;
	logic              slot_free;

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign slot_free    = !out_valid_q || result.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= RST_MIN_DUTY;
			max_q   <= RST_MAX_DUTY;
			db_q    <= RST_DEADBAND;
			accel_q <= RST_ACCEL_STEP;
			decel_q <= RST_DECEL_STEP;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_DUTY:   min_q   <= cfg.data[DUTY_W-1:0];
				REG_MAX_DUTY:   max_q   <= cfg.data[DUTY_W-1:0];
				REG_DEADBAND:   db_q    <= cfg.data;
				REG_ACCEL_STEP: accel_q <= cfg.data[DUTY_W-1:0];
				REG_DECEL_STEP: decel_q <= cfg.data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// magnitude; -1024 maps to 1024, still fits 11 bits unsigned
	assign err_u = sample.position_error;

	// target selection
	assign outside    = mag_q > MAG_W'(db_q);
	assign excess     = mag_q - MAG_W'(db_q);
	assign span       = (FSE > SPAN_W'(db_q)) ? (FSE - SPAN_W'(db_q)) : '0;
	assign min_gt_max = min_q > max_q;
	// excess < span/20  <=>  20*(excess+1) <= span
	assign ex1        = {1'b0, excess} + 1'b1;
	assign lim20      = CMP_W'({ex1, 4'b0}) + CMP_W'({ex1, 2'b0});
	assign spread     = max_q - min_q;
	assign product    = PROD_W'(excess) * PROD_W'(spread);
	assign div_start  = (state_q == ST_PREP) && outside && !min_gt_max && (span != '0)
		&& (lim20 > CMP_W'(span));

	always_comb begin
		priority if (!outside) begin
			prep_target = '0;
		end else if (min_gt_max || span == '0) begin
			prep_target = max_q;
		end else begin
			prep_target = min_q;
		end
	end

	pmdr_div #(
		.DVD_W(PROD_W),
		.DVS_W(SPAN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (span),
		.stat    (dstat),
		.quotient(quot)
	);

	assign prop_sum    = PROD_W'(min_q) + {1'b0, quot};
	assign prop_target = (prop_sum > (PROD_W + 1)'(max_q)) ? max_q : prop_sum[DUTY_W-1:0];

	// slew limit
	always_comb begin
		duty_next = duty_q;
		step_diff = '0;
		if (target_q > duty_q) begin
			step_diff = target_q - duty_q;
			duty_next = duty_q + ((step_diff > accel_q) ? accel_q : step_diff);
		end else if (target_q < duty_q) begin
			step_diff = duty_q - target_q;
			duty_next = duty_q - ((step_diff > decel_q) ? decel_q : step_diff);
		end
	end

	always_comb begin
		dir_next = dir_q;
		if (duty_next == '0) begin
			dir_next = DIR_STOP;
		end else if (outside_q) begin
			dir_next = neg_q ? DIR_LEFT : DIR_RIGHT;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			duty_q      <= '0;
			dir_q       <= DIR_STOP;
			out_valid_q <= 1'b0;
		end else begin
			// in the ramp step a result transfer frees the slot and the new result takes it
			if (result.valid && result.ready && state_q != ST_RAMP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= div_start ? ST_DIV : ST_RAMP;
				end
				ST_DIV: begin
					if (dstat.done) begin
						state_q <= ST_RAMP;
					end
				end
				ST_RAMP: begin
					if (slot_free) begin
						duty_q      <= duty_next;
						dir_q       <= dir_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample.valid) begin
			neg_q <= err_u[MAG_W-1];
			mag_q <= err_u[MAG_W-1] ? (~err_u + 1'b1) : err_u;
		end
		if (state_q == ST_PREP) begin
			outside_q <= outside;
			target_q  <= prep_target;
		end
		if (state_q == ST_DIV && dstat.done) begin
			target_q <= prop_target;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.duty_percent = duty_q;
	assign result.drive_enable = (duty_q != '0);
	assign result.direction    = dir_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	a_result_from_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RAMP))
		else $error("result raised outside ramp step");

	a_zero_duty_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && duty_q == '0 |-> dir_q == DIR_STOP)
		else $error("zero duty with a driven direction");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(duty_q) && $stable(dir_q))
		else $error("duty state moved while result held");

endmodule
`default_nettype wire

/* tb/tb.sv */
module tb;
	import pmdr_pkg::*;

	localparam int FULL_SCALE     = 1023;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 150;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 55;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              en;
		dir_t              dir;
	} drive_t;

	logic clk;
	logic arst_n;

	pmdr_in_if  sample_if();
	pmdr_out_if result_if();
	pmdr_cfg_if cfg_if();

	proportional_motor_drive_with_ramp #(
		.FULL_SCALE_ERROR(FULL_SCALE)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_if),
		.result(result_if),
		.cfg   (cfg_if)
	);

	// shadow of the control registers and of the drive state
	logic [DUTY_W-1:0] lim_min;
	logic [DUTY_W-1:0] lim_max;
	logic [DB_W-1:0]   lim_deadband;
	logic [DUTY_W-1:0] step_up;
	logic [DUTY_W-1:0] step_down;
	logic [DUTY_W-1:0] last_duty;
	dir_t              last_dir;

	logic signed [ERR_W-1:0] pending_errors[$];
	drive_t                  expected_drive[$];

	int  err_count;
	int  quiet_cycles;
	int  send_gap;
	int  recv_gap;
	int  hold_left;
	bit  hold_req;
	bit  allow_idle;
	drive_t want;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// duty target from the error magnitude, then slew limit and direction latch
	function automatic drive_t drive_from_error(logic signed [ERR_W-1:0] err);
		int unsigned raw;
		int unsigned mag;
		int unsigned over;
		int unsigned span;
		int unsigned tgt;
		int unsigned duty;
		int unsigned diff;
		int unsigned mn;
		int unsigned mx;
		int unsigned db;
		int unsigned up;
		int unsigned dn;
		int unsigned fs;
		logic        neg;
		drive_t      r;
		mn  = 32'(lim_min);
		mx  = 32'(lim_max);
		db  = 32'(lim_deadband);
		up  = 32'(step_up);
		dn  = 32'(step_down);
		fs  = 32'(FULL_SCALE);
		raw = {21'b0, err};
		neg = err[ERR_W-1];
		mag = neg ? (32'd1 << ERR_W) - raw : raw;
		if (mag <= db) begin
			tgt = 0;
		end else begin
			over = mag - db;
			span = (fs > db) ? fs - db : 0;
			if (mn > mx) begin
				tgt = mx;
			end else begin
				if (span == 0)
					tgt = mx;
				else if (over < span / 20)
					tgt = mn;
				else
					tgt = mn + (over * (mx - mn)) / span;
				if (tgt < mn)
					tgt = mn;
				if (tgt > mx)
					tgt = mx;
			end
		end
		duty = 32'(last_duty);
		if (tgt > duty) begin
			diff = tgt - duty;
			duty = duty + ((diff > up) ? up : diff);
		end else if (tgt < duty) begin
			diff = duty - tgt;
			duty = duty - ((diff > dn) ? dn : diff);
		end
		if (duty > 0) begin
			// inside the deadband the direction holds
			if (mag > db)
				last_dir = neg ? DIR_LEFT : DIR_RIGHT;
		end else begin
			last_dir = DIR_STOP;
		end
		last_duty = duty[DUTY_W-1:0];
		r.duty = last_duty;
		r.en   = (duty > 0);
		r.dir  = last_dir;
		return r;
	endfunction

	function automatic logic signed [ERR_W-1:0] rand_error();
		int                      m;
		logic signed [ERR_W-1:0] e;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// around the deadband edge
				m = int'(lim_deadband) + int'($urandom_range(0, 40)) - 20;
				if (m < 0)
					m = 0;
				e = ERR_W'(m);
				if ($urandom_range(0, 1))
					e = -e;
			end
			3: begin
				case ($urandom_range(0, 4))
					0: e = 11'h3FF;
					1: e = 11'h401;
					2: e = 11'h400;
					3: e = 11'h000;
					default: e = 11'h7FF;
				endcase
			end
			default: e = ERR_W'($urandom_range(0, (1 << ERR_W) - 1));
		endcase
		return e;
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready)
				expected_drive.push_back(drive_from_error(sample_if.position_error));
			if (!sample_if.valid || sample_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_if.valid <= 1'b0;
				end else if (pending_errors.size() > 0) begin
					sample_if.valid          <= 1'b1;
					sample_if.position_error <= pending_errors.pop_front();
					if (allow_idle && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 5);
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (expected_drive.size() == 0) begin
					$error("unexpected transfer: duty_percent %0d drive_enable %0d direction %0d",
						result_if.duty_percent, result_if.drive_enable, result_if.direction);
					err_count++;
				end else begin
					want = expected_drive.pop_front();
					if (result_if.duty_percent !== want.duty) begin
						$error("duty_percent: expected %0d, got %0d", want.duty,
							result_if.duty_percent);
						err_count++;
					end
					if (result_if.drive_enable !== want.en) begin
						$error("drive_enable: expected %0d, got %0d", want.en,
							result_if.drive_enable);
						err_count++;
					end
					if (result_if.direction !== want.dir) begin
						$error("direction: expected %0d, got %0d", want.dir,
							result_if.direction);
						err_count++;
					end
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (allow_idle && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
			(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// call at a rising edge; leaves valid high for a following write
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_MIN_DUTY:   lim_min      = value[DUTY_W-1:0];
			REG_MAX_DUTY:   lim_max      = value[DUTY_W-1:0];
			REG_DEADBAND:   lim_deadband = value[DB_W-1:0];
			REG_ACCEL_STEP: step_up      = value[DUTY_W-1:0];
			REG_DECEL_STEP: step_down    = value[DUTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [DATA_W-1:0] mn, logic [DATA_W-1:0] mx,
		logic [DATA_W-1:0] db, logic [DATA_W-1:0] ac, logic [DATA_W-1:0] dc);
		@(posedge clk);
		write_reg(REG_MIN_DUTY, mn);
		write_reg(REG_MAX_DUTY, mx);
		write_reg(REG_DEADBAND, db);
		write_reg(REG_ACCEL_STEP, ac);
		write_reg(REG_DECEL_STEP, dc);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_random();
		logic [DATA_W-1:0] mn;
		logic [DATA_W-1:0] mx;
		logic [DATA_W-1:0] db;
		logic [DATA_W-1:0] ac;
		logic [DATA_W-1:0] dc;
		case ($urandom_range(0, 5))
			0: begin
				mn = DATA_W'($urandom_range(0, 255));
				mx = DATA_W'($urandom_range(0, 255));
				db = DATA_W'($urandom_range(0, 255));
				ac = DATA_W'($urandom_range(0, 255));
				dc = DATA_W'($urandom_range(0, 255));
			end
			1: begin
				mn = $urandom_range(0, 1) ? 8'd0 : 8'd100;
				mx = $urandom_range(0, 1) ? 8'd0 : 8'd100;
				db = $urandom_range(0, 1) ? 8'd0 : 8'd255;
				ac = $urandom_range(0, 1) ? 8'd1 : 8'd100;
				dc = $urandom_range(0, 1) ? 8'd1 : 8'd100;
			end
			default: begin
				mn = DATA_W'($urandom_range(0, 60));
				mx = DATA_W'($urandom_range(32'(mn), 100));
				db = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 255))
					: DATA_W'($urandom_range(0, 40));
				ac = DATA_W'($urandom_range(1, 20));
				dc = DATA_W'($urandom_range(1, 20));
			end
		endcase
		program_regs(mn, mx, db, ac, dc);
	endtask

	task automatic queue_errors(int vals[]);
		logic signed [ERR_W-1:0] e;
		foreach (vals[i]) begin
			e = ERR_W'(vals[i]);
			pending_errors.push_back(e);
		end
	endtask

	// sender pauses here until every expected result has come back
	task automatic settle();
		do
			@(negedge clk);
		while (pending_errors.size() != 0 || sample_if.valid || expected_drive.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		sample_if.valid          = 1'b0;
		sample_if.position_error = '0;
		result_if.ready          = 1'b0;
		cfg_if.valid             = 1'b0;
		cfg_if.index             = REG_MIN_DUTY;
		cfg_if.data              = '0;
		lim_min                  = RST_MIN_DUTY;
		lim_max                  = RST_MAX_DUTY;
		lim_deadband             = RST_DEADBAND;
		step_up                  = RST_ACCEL_STEP;
		step_down                = RST_DECEL_STEP;
		last_duty                = '0;
		last_dir                 = DIR_STOP;
		allow_idle               = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: deadband edge, full scale, most negative, direction hold
		queue_errors('{0, 3, 6, -6, 1023, 1023, 2, -1024, -1024, 1, 30, -1023});
		settle();
		// min above max
		program_regs(8'd100, 8'd0, 8'd255, 8'd1, 8'd1);
		queue_errors('{300, -1023, 256, 255});
		settle();
		// no deadband, widest span, steps that cover the whole duty range
		program_regs(8'd0, 8'd100, 8'd0, 8'd100, 8'd100);
		queue_errors('{1023, -1, -1024, 0, 52});
		settle();
		// zero steps freeze the duty; upper data bits dropped
		program_regs(8'hFF, 8'hFF, 8'd0, 8'd0, 8'h80);
		queue_errors('{1023, -5, 0});
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			program_random();
			if (p == RANDOM_PHASES - 1)
				allow_idle = 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_errors.push_back(rand_error());
			// receiver holds off while the sender keeps offering
			if (p == 2)
				hold_req = 1'b1;
			settle();
		end

		repeat (30) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pmdr_pkg.sv
rtl/core/pmdr_if.sv
rtl/core/pmdr_div.sv
rtl/core/proportional_motor_drive_with_ramp.sv
tb/tb.sv
